[rtl/core/cvgpc_pkg.sv]
// Shared types and constants for the CV/gate pitch calibrator.
// Holds the request codes, result kinds, phase and sequencer encodings.
// No dependencies.
`timescale 1ns / 1ps

package cvgpc_pkg;

    // Default number of fraction bits of the semitone step
    localparam int CVGPC_STEP_FRAC_BITS = 16;

    // Field widths
    localparam int CVGPC_SAMPLE_W   = 12;
    localparam int CVGPC_RUN_W      = 16;
    localparam int CVGPC_SUM_W      = 28;
    localparam int CVGPC_CNT_W      = 16;
    localparam int CVGPC_NOTE_IDX_W = 7;
    localparam int CVGPC_VALUE_W    = 16;
    localparam int CVGPC_CFG_IDX_W  = 1;
    localparam int CVGPC_CFG_DATA_W = 16;

    // Register reset values
    localparam logic [15:0] CVGPC_DEBOUNCE_RST = 16'd50000;
    localparam logic [11:0] CVGPC_REJECT_RST   = 12'd3000;

    // Pitch constants: C4 note number, semitones per octave, C4 to G4
    localparam logic [7:0]  CVGPC_C4_NOTE    = 8'd48;
    localparam logic [15:0] CVGPC_SEMITONES  = 16'd12;
    localparam logic [3:0]  CVGPC_FIFTH_SEMI = 4'd7;

    // Register indexes
    localparam logic [CVGPC_CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CVGPC_CFG_IDX_W-1:0] REG_REJECT   = 1'b1;

    // Reference note slots
    localparam logic [1:0] SLOT_C4   = 2'd0;
    localparam logic [1:0] SLOT_G4   = 2'd1;
    localparam logic [1:0] SLOT_C5   = 2'd2;
    localparam logic [1:0] SLOT_DONE = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_READ    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_NONE       = 3'd0,
        KIND_CAPTURED   = 3'd1,
        KIND_CALIBRATED = 3'd2,
        KIND_FAILED     = 3'd3,
        KIND_READ       = 3'd4,
        KIND_REFUSED    = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        PH_WAIT_LOW  = 3'd0,
        PH_WAIT_HIGH = 3'd1,
        PH_CAPTURE   = 3'd2,
        PH_REJECTED  = 3'd3,
        PH_RELEASE   = 3'd4,
        PH_DONE_OK   = 3'd5,
        PH_DONE_FAIL = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE      = 3'd0,
        SQ_AVG_DIV   = 3'd1,
        SQ_STEP_DIV  = 3'd2,
        SQ_ERR       = 3'd3,
        SQ_CHECK     = 3'd4,
        SQ_READ_MUL  = 3'd5,
        SQ_READ_SUM  = 3'd6,
        SQ_READ_OUT  = 3'd7
    } t_seq;

endpackage

[rtl/core/cv_gate_pitch_calibrator_unit.sv]
// A plain tick, restart or refused read gives its result in the cycle after the request.
// A tick that completes a note runs the averaging divide; the tick that completes the third
// release runs the step divide, then the error and check states; a note read goes through the
// multiply, sum and output states. One request at a time; the serial divider is shared, one
// quotient bit per cycle. Reset is synchronous, active low: control and config registers
// return to defaults, calibration restarts at wait-for-gate-low. Depends on cvgpc_pkg.
`timescale 1ns / 1ps

module cv_gate_pitch_calibrator_unit
    import cvgpc_pkg::*;
#(
    parameter int STEP_FRACTION_BITS = CVGPC_STEP_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_op,
    input  logic                               i_gate,
    input  logic [CVGPC_SAMPLE_W-1:0]          i_sample,
    input  logic [CVGPC_NOTE_IDX_W-1:0]        i_note_index,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [2:0]                         o_kind,
    output logic [1:0]                         o_note_slot,
    output logic signed [CVGPC_VALUE_W-1:0]    o_value,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [CVGPC_CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CVGPC_CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int F      = STEP_FRACTION_BITS;
    localparam int STEP_W = F + 10;
    localparam int ERR_W  = F + 14;
    localparam int P_W    = STEP_W + 8;
    localparam int Q_W    = STEP_W + 9;
    localparam int DIV_W  = (F + 12 > CVGPC_SUM_W) ? (F + 12) : CVGPC_SUM_W;
    localparam int DEN_W  = CVGPC_CNT_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    localparam logic [Q_W-1:0] FRAC_MASK = {{(Q_W - F){1'b0}}, {F{1'b1}}};
    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(32'sd32767);
    localparam logic signed [Q_W-1:0] SAT_LO = Q_W'(-32'sd32768);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_seq   r_seq,   n_seq;
    t_phase r_phase, n_phase;

    logic [CVGPC_RUN_W-1:0]    r_run, n_run;
    logic [CVGPC_SUM_W-1:0]    r_sum, n_sum;
    logic [CVGPC_CNT_W-1:0]    r_cnt, n_cnt;
    logic [1:0]                r_slot, n_slot;
    logic [CVGPC_SAMPLE_W-1:0] r_note [3];
    logic                      n_note_we;
    logic [CVGPC_SAMPLE_W-1:0] n_note_val;
    logic signed [STEP_W-1:0]  r_step, n_step;
    logic                      r_step_neg, n_step_neg;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic signed [7:0]         r_offset, n_offset;
    logic signed [P_W-1:0]     r_prod, n_prod;
    logic signed [Q_W-1:0]     r_q, n_q;

    logic [15:0]               r_debounce;
    logic [CVGPC_SAMPLE_W-1:0] r_reject;

    logic                      r_out_valid, n_out_valid;
    t_kind                     r_kind, n_kind;
    logic [1:0]                r_out_slot, n_out_slot;
    logic [CVGPC_VALUE_W-1:0]  r_value, n_value;

    // shared serial divider
    logic [DEN_W-1:0]  r_div_rem;
    logic [DIV_W-1:0]  r_div_quo;
    logic [DEN_W-1:0]  r_div_den;
    logic [DCNT_W-1:0] r_div_left;
    logic              w_div_start;
    logic [DIV_W-1:0]  w_div_num;
    logic [DEN_W-1:0]  w_div_den;
    logic [DEN_W:0]    w_div_shift;
    logic [DEN_W+1:0]  w_div_diff;
    logic              w_div_borrow;

    // ---------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------
    logic                      w_in_fire;
    logic                      w_out_take;
    t_op                       w_op;
    logic [CVGPC_RUN_W-1:0]    w_run_base;
    logic [CVGPC_SUM_W-1:0]    w_sum_base;
    logic [CVGPC_CNT_W-1:0]    w_cnt_base;
    logic [CVGPC_RUN_W-1:0]    w_run_inc;
    logic                      w_in_window;
    logic [CVGPC_SUM_W-1:0]    w_sum_new;
    logic [CVGPC_CNT_W-1:0]    w_cnt_new;
    logic [CVGPC_RUN_W-1:0]    w_rel_inc;
    logic signed [12:0]        w_oct;
    logic [11:0]               w_oct_abs;
    logic signed [12:0]        w_n01;
    logic [DIV_W-1:0]          w_avg;
    logic signed [STEP_W-1:0]  w_step_q;
    logic [ERR_W-1:0]          w_abs_err;
    logic                      w_fail;
    logic [CVGPC_VALUE_W-1:0]  w_err_int;
    logic signed [Q_W-1:0]     w_q_adj;
    logic signed [Q_W-1:0]     w_q_int;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_take = r_out_valid && i_out_ready;
    assign w_op       = t_op'(i_op);

    // high-run accumulation; a run entered from wait-for-high starts clean
    assign w_run_base  = (r_phase == PH_WAIT_HIGH) ? '0 : r_run;
    assign w_sum_base  = (r_phase == PH_WAIT_HIGH) ? '0 : r_sum;
    assign w_cnt_base  = (r_phase == PH_WAIT_HIGH) ? '0 : r_cnt;
    assign w_run_inc   = (&w_run_base) ? w_run_base : w_run_base + 1'b1;
    assign w_in_window = w_run_inc > (r_debounce >> 2);
    assign w_sum_new   = w_in_window ? w_sum_base + CVGPC_SUM_W'(i_sample) : w_sum_base;
    assign w_cnt_new   = (w_in_window && !(&w_cnt_base)) ? w_cnt_base + 1'b1 : w_cnt_base;

    // low-run count during release
    assign w_rel_inc = (&r_run) ? r_run : r_run + 1'b1;

    // octave span and C4-G4 difference
    assign w_oct     = $signed({1'b0, r_note[SLOT_C5]}) - $signed({1'b0, r_note[SLOT_C4]});
    assign w_oct_abs = w_oct[12] ? 12'(-w_oct) : w_oct[11:0];
    assign w_n01     = $signed({1'b0, r_note[SLOT_C4]}) - $signed({1'b0, r_note[SLOT_G4]});

    // divider results
    assign w_avg    = (r_div_den == '0) ? '0 : r_div_quo;
    assign w_step_q = r_step_neg ? -$signed(STEP_W'(r_div_quo)) : $signed(STEP_W'(r_div_quo));

    // tolerance check: fail when twice the error exceeds the step
    assign w_abs_err = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
    assign w_fail    = $signed({1'b0, w_abs_err, 1'b0}) > (ERR_W + 2)'(r_step);
    assign w_err_int = CVGPC_VALUE_W'(w_abs_err >> F);

    // read value, truncated toward zero
    assign w_q_adj = r_q + $signed(r_q[Q_W-1] ? FRAC_MASK : '0);
    assign w_q_int = w_q_adj >>> F;

    // ---------------------------------------------------------------
    // Sequencer: next state and outputs
    // ---------------------------------------------------------------
    always_comb begin
        n_seq       = r_seq;
        n_phase     = r_phase;
        n_run       = r_run;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_note_we   = 1'b0;
        n_note_val  = w_avg[CVGPC_SAMPLE_W-1:0];
        n_step      = r_step;
        n_step_neg  = r_step_neg;
        n_err       = r_err;
        n_offset    = r_offset;
        n_prod      = r_prod;
        n_q         = r_q;
        n_out_valid = w_out_take ? 1'b0 : r_out_valid;
        n_kind      = r_kind;
        n_out_slot  = r_out_slot;
        n_value     = r_value;
        w_div_start = 1'b0;
        w_div_num   = DIV_W'(w_sum_new);
        w_div_den   = w_cnt_new;

        unique case (r_seq)
            SQ_IDLE: begin
                if (w_in_fire) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_NONE;
                    n_out_slot  = SLOT_C4;
                    n_value     = '0;
                    unique case (w_op)
                        OP_READ: begin
                            if (r_phase == PH_DONE_OK) begin
                                n_out_valid = 1'b0;
                                n_offset    = $signed({1'b0, i_note_index}) - $signed(CVGPC_C4_NOTE);
                                n_seq       = SQ_READ_MUL;
                            end else begin
                                n_kind = KIND_REFUSED;
                            end
                        end
                        OP_RESTART: begin
                            n_phase = PH_WAIT_LOW;
                            n_run   = '0;
                            n_sum   = '0;
                            n_cnt   = '0;
                            n_slot  = SLOT_C4;
                            n_step  = '0;
                        end
                        OP_TICK: begin
                            unique case (r_phase)
                                PH_WAIT_LOW: begin
                                    if (!i_gate) n_phase = PH_WAIT_HIGH;
                                end
                                PH_WAIT_HIGH, PH_CAPTURE: begin
                                    if (!i_gate) begin
                                        n_run = '0;
                                        n_sum = '0;
                                        n_cnt = '0;
                                    end else if (w_run_inc >= r_debounce) begin
                                        // run accepted: average it on the divider
                                        n_phase     = PH_CAPTURE;
                                        n_run       = '0;
                                        n_sum       = '0;
                                        n_cnt       = '0;
                                        n_out_valid = 1'b0;
                                        w_div_start = 1'b1;
                                        n_seq       = SQ_AVG_DIV;
                                    end else begin
                                        n_phase = PH_CAPTURE;
                                        n_run   = w_run_inc;
                                        n_sum   = w_sum_new;
                                        n_cnt   = w_cnt_new;
                                    end
                                end
                                PH_REJECTED: begin
                                    if (!i_gate) begin
                                        n_run   = '0;
                                        n_sum   = '0;
                                        n_cnt   = '0;
                                        n_phase = PH_CAPTURE;
                                    end
                                end
                                PH_RELEASE: begin
                                    if (i_gate) begin
                                        n_run = '0;
                                    end else if (w_rel_inc >= r_debounce) begin
                                        n_run = '0;
                                        n_sum = '0;
                                        n_cnt = '0;
                                        if (r_slot == SLOT_C5) begin
                                            // last note released: step = octave / 12
                                            n_slot      = SLOT_DONE;
                                            n_step_neg  = w_oct[12];
                                            n_out_valid = 1'b0;
                                            w_div_start = 1'b1;
                                            w_div_num   = DIV_W'({w_oct_abs, {F{1'b0}}});
                                            w_div_den   = CVGPC_SEMITONES;
                                            n_seq       = SQ_STEP_DIV;
                                        end else begin
                                            n_slot  = r_slot + 1'b1;
                                            n_phase = PH_CAPTURE;
                                        end
                                    end else begin
                                        n_run = w_rel_inc;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            SQ_AVG_DIV: begin
                if (r_div_left == '0) begin
                    n_seq       = SQ_IDLE;
                    n_out_valid = 1'b1;
                    n_kind      = KIND_NONE;
                    n_out_slot  = SLOT_C4;
                    n_value     = '0;
                    if (w_avg > DIV_W'(r_reject)) begin
                        n_phase = PH_REJECTED;
                    end else begin
                        n_note_we  = 1'b1;
                        n_kind     = KIND_CAPTURED;
                        n_out_slot = r_slot;
                        n_value    = CVGPC_VALUE_W'(w_avg[CVGPC_SAMPLE_W-1:0]);
                        n_phase    = PH_RELEASE;
                    end
                end
            end
            SQ_STEP_DIV: begin
                if (r_div_left == '0) begin
                    n_step = w_step_q;
                    n_seq  = SQ_ERR;
                end
            end
            SQ_ERR: begin
                // err = (C4 - G4) * 2^F + 7 * step
                n_err = (ERR_W'(w_n01) <<< F)
                      + ERR_W'(r_step) * $signed(ERR_W'(CVGPC_FIFTH_SEMI));
                n_seq = SQ_CHECK;
            end
            SQ_CHECK: begin
                n_seq       = SQ_IDLE;
                n_out_valid = 1'b1;
                n_out_slot  = SLOT_C4;
                if (w_fail) begin
                    n_phase = PH_DONE_FAIL;
                    n_kind  = KIND_FAILED;
                    n_value = r_err[ERR_W-1] ? -w_err_int : w_err_int;
                end else begin
                    n_phase = PH_DONE_OK;
                    n_kind  = KIND_CALIBRATED;
                    n_value = '0;
                end
            end
            SQ_READ_MUL: begin
                n_prod = P_W'(r_step) * P_W'(r_offset);
                n_seq  = SQ_READ_SUM;
            end
            SQ_READ_SUM: begin
                n_q   = (Q_W'($signed({1'b0, r_note[SLOT_C4]})) <<< F) + Q_W'(r_prod);
                n_seq = SQ_READ_OUT;
            end
            SQ_READ_OUT: begin
                n_seq       = SQ_IDLE;
                n_out_valid = 1'b1;
                n_kind      = KIND_READ;
                n_out_slot  = SLOT_C4;
                if (w_q_int > SAT_HI) begin
                    n_value = SAT_HI[CVGPC_VALUE_W-1:0];
                end else if (w_q_int < SAT_LO) begin
                    n_value = SAT_LO[CVGPC_VALUE_W-1:0];
                end else begin
                    n_value = w_q_int[CVGPC_VALUE_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer and control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_phase     <= PH_WAIT_LOW;
            r_run       <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_slot      <= SLOT_C4;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_run       <= n_run;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_slot      <= n_slot;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_step_neg <= n_step_neg;
        r_err      <= n_err;
        r_offset   <= n_offset;
        r_prod     <= n_prod;
        r_q        <= n_q;
        r_kind     <= n_kind;
        r_out_slot <= n_out_slot;
        r_value    <= n_value;
        if (n_note_we) r_note[r_slot] <= n_note_val;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= CVGPC_DEBOUNCE_RST;
            r_reject   <= CVGPC_REJECT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE: r_debounce <= i_cfg_data;
                REG_REJECT:   r_reject   <= i_cfg_data[CVGPC_SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Shared restoring divider, one quotient bit per cycle
    // ---------------------------------------------------------------
    assign w_div_shift  = {r_div_rem, r_div_quo[DIV_W-1]};
    assign w_div_diff   = {1'b0, w_div_shift} - {2'b00, r_div_den};
    assign w_div_borrow = w_div_diff[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_left <= '0;
        end else if (w_div_start) begin
            r_div_left <= DCNT_W'(DIV_W);
        end else if (r_div_left != '0) begin
            r_div_left <= r_div_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_div_rem <= '0;
            r_div_quo <= w_div_num;
            r_div_den <= w_div_den;
        end else if (r_div_left != '0) begin
            r_div_rem <= w_div_borrow ? w_div_shift[DEN_W-1:0] : w_div_diff[DEN_W-1:0];
            r_div_quo <= {r_div_quo[DIV_W-2:0], ~w_div_borrow};
        end
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign o_in_ready  = (r_seq == SQ_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_note_slot = r_out_slot;
    assign o_value     = $signed(r_value);

`ifndef SYNTHESIS
    // a long request never finds the result register occupied
    a_busy_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != SQ_IDLE) |-> !r_out_valid)
        else $error("result register full while sequencer busy");

    // divider runs only under a divide state
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_left != '0) |-> (r_seq == SQ_AVG_DIV || r_seq == SQ_STEP_DIV))
        else $error("divider active outside a divide step");

    // with the sequencer idle, capture phases always point at a real reference slot
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_IDLE && (r_phase == PH_CAPTURE || r_phase == PH_REJECTED ||
         r_phase == PH_RELEASE)) |-> (r_slot != SLOT_DONE))
        else $error("capture phase with no slot left");

    // a finished calibration always has all three notes
    a_done_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE_OK || r_phase == PH_DONE_FAIL) |-> (r_slot == SLOT_DONE))
        else $error("calibration ended early");
`endif

endmodule
